@@ rtl/mols_pkg.sv @@
`default_nettype none
package mols_pkg;

  localparam int SAMPLE_W = 32;
  localparam int MEDIAN_W = 33;
  localparam int COUNT_W  = 7;

  typedef enum logic {
    ST_LOAD,
    ST_SEEK
  } mols_state_t;

  // broadcast from the controller to every cell of the chain
  typedef struct packed {
    logic                       insert;
    logic                       shift;
    logic                       clear;
    logic signed [SAMPLE_W-1:0] sample;
  } mols_cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/mols_in_if.sv @@
`default_nettype none
interface mols_in_if;
  import mols_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/mols_out_if.sv @@
`default_nettype none
interface mols_out_if;
  import mols_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [MEDIAN_W-1:0] median_value;
  logic                       overflowed;
  logic        [COUNT_W-1:0]  sample_count;

  modport source (output valid, output median_value, output overflowed,
                  output sample_count, input ready);
  modport sink   (input valid, input median_value, input overflowed,
                  input sample_count, output ready);
endinterface
`default_nettype wire

@@ rtl/mols_cell.sv @@
`default_nettype none
module mols_cell (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire mols_pkg::mols_cell_ctl_t             ctl,
  input  wire logic signed [mols_pkg::SAMPLE_W-1:0] left_val,
  input  wire logic                                 left_valid,
  input  wire logic                                 left_gt,
  input  wire logic signed [mols_pkg::SAMPLE_W-1:0] right_val,
  input  wire logic                                 right_valid,
  output logic signed [mols_pkg::SAMPLE_W-1:0]      val,
  output logic                                      valid,
  output logic                                      gt
);
  import mols_pkg::*;

  logic signed [SAMPLE_W-1:0] val_r, val_nxt;
  logic                       valid_r, valid_nxt;
  logic signed [SAMPLE_W-1:0] ins_val;

  // strict compare keeps a new word behind the equal ones
  assign gt      = valid_r && (val_r > ctl.sample);
  assign ins_val = left_gt ? left_val : ctl.sample;

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.shift) begin
      val_nxt   = right_val;
      valid_nxt = right_valid;
    end else if (ctl.insert) begin
      if (gt) begin
        val_nxt = ins_val;
      end else if (!valid_r && left_valid) begin
        // first empty slot takes the displaced tail or the new word
        val_nxt   = ins_val;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val   = val_r;
  assign valid = valid_r;

endmodule
`default_nettype wire

@@ rtl/median_of_loaded_set.sv @@
`default_nettype none
// Loading: one sample word per cycle while ready; an accepted word goes into the sorted
// cell chain, or is dropped and flagged when full. After the word marked last, the chain
// shifts left floor((k-1)/2) places (k = kept count) to bring the middle elements to
// cells 0 and 1; the result is registered once that walk ends and the output is free.
// Input stalls till the result is registered; a waiting result does not block new loads.
// Synchronous active-low reset empties the chain; clears count, drop flag, output valid.
module median_of_loaded_set #(
  parameter int MAX_SAMPLES = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mols_in_if.sink    in_bus,
  mols_out_if.source out_bus
);
  import mols_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  mols_state_t    state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  seek_r, seek_nxt;
  logic           drop_r, drop_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic signed [MEDIAN_W-1:0] median_r;
  logic                       overflowed_r;
  logic        [COUNT_W-1:0]  count_out_r;

  mols_cell_ctl_t ctl;
  logic           accept_in;
  logic           full;
  logic [CW-1:0]  count_new;
  logic           load_out;
  logic signed [MEDIAN_W-1:0] median_calc;

  logic signed [SAMPLE_W-1:0] cell_val [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0]     cell_valid;
  logic [MAX_SAMPLES-1:0]     cell_gt;

  assign in_bus.ready = (state_r == ST_LOAD);
  assign accept_in    = in_bus.valid && in_bus.ready;
  assign full         = (count_r == CW'(MAX_SAMPLES));
  assign count_new    = full ? count_r : count_r + CW'(1);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    seek_nxt   = seek_r;
    drop_nxt   = drop_r;
    load_out   = 1'b0;
    ctl.insert = 1'b0;
    ctl.shift  = 1'b0;
    ctl.clear  = 1'b0;
    ctl.sample = in_bus.sample;
    case (state_r)
      ST_LOAD: begin
        if (accept_in) begin
          ctl.insert = !full;
          count_nxt  = count_new;
          drop_nxt   = drop_r | full;
          if (in_bus.last) begin
            seek_nxt  = CW'((count_new - CW'(1)) >> 1);
            state_nxt = ST_SEEK;
          end
        end
      end
      ST_SEEK: begin
        if (seek_r != '0) begin
          ctl.shift = 1'b1;
          seek_nxt  = seek_r - CW'(1);
        end else if (!out_valid_r || out_bus.ready) begin
          load_out  = 1'b1;
          ctl.clear = 1'b1;
          count_nxt = '0;
          drop_nxt  = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // odd count: middle word doubled; even: sum of the two middle words
  always_comb begin
    if (count_r[0]) begin
      median_calc = {cell_val[0], 1'b0};
    end else begin
      median_calc = {cell_val[0][SAMPLE_W-1], cell_val[0]}
                  + {cell_val[1][SAMPLE_W-1], cell_val[1]};
    end
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_bus.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      seek_r      <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      seek_r      <= seek_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      median_r     <= median_calc;
      overflowed_r <= drop_r;
      count_out_r  <= COUNT_W'(count_r);
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.median_value = median_r;
  assign out_bus.overflowed   = overflowed_r;
  assign out_bus.sample_count = count_out_r;

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    logic signed [SAMPLE_W-1:0] l_val, r_val;
    logic                       l_valid, l_gt, r_valid;

    if (i == 0) begin : g_head
      assign l_val   = '0;
      assign l_valid = 1'b1;
      assign l_gt    = 1'b0;
    end else begin : g_body
      assign l_val   = cell_val[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_gt    = cell_gt[i-1];
    end

    if (i == MAX_SAMPLES - 1) begin : g_tail
      assign r_val   = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid
      assign r_val   = cell_val[i+1];
      assign r_valid = cell_valid[i+1];
    end

    mols_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_val    (l_val),
      .left_valid  (l_valid),
      .left_gt     (l_gt),
      .right_val   (r_val),
      .right_valid (r_valid),
      .val         (cell_val[i]),
      .valid       (cell_valid[i]),
      .gt          (cell_gt[i])
    );
  end

  // while loading, the filled cells match the kept count
  a_fill_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> ($countones(cell_valid) == int'(count_r)))
    else $error("cell fill does not match kept count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SAMPLES))
    else $error("kept count beyond capacity");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_LOAD) && (count_r >= CW'(2))) |-> (cell_val[0] <= cell_val[1]))
    else $error("chain head out of order");

  a_set_closed: assert property (@(posedge clk) disable iff (!rst_n)
    $past(load_out) |-> ((count_r == '0) && !drop_r && (state_r == ST_LOAD)))
    else $error("set not closed after result");

endmodule
`default_nettype wire
